/* hdl/sbdt_pkg.sv */
// ----------------------------------------------------------------------------
// sbdt_pkg
// Shared codes, widths and controller/datapath interface types for the
// sector buffer dirty tracker.
// ----------------------------------------------------------------------------
package sbdt_pkg;

  // Dirty store row geometry: one memory row holds this many dirty bits.
  localparam int ROW_W  = 8;
  localparam int ROW_BW = 3;

  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

  // Request kinds.
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_NODEV = 2'd2;

  // Result routes.
  localparam logic [1:0] ROUTE_RAM  = 2'd0;
  localparam logic [1:0] ROUTE_PIO  = 2'd1;
  localparam logic [1:0] ROUTE_BIOS = 2'd2;
  localparam logic [1:0] ROUTE_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BUFFERED  = 2'd0;
  localparam logic [1:0] CFG_PARTITION = 2'd1;
  localparam logic [1:0] CFG_HW        = 2'd2;
  localparam logic [1:0] CFG_DRIVE     = 2'd3;

  // Row address source for a dirty store read.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_ACCESS,
    RD_PENDING,
    RD_CURSOR,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    latch;
    logic    clr;
    logic    decode;
    rd_sel_t rd_sel;
    logic    mark;
    logic    unmark;
    logic    scan_eval;
    logic    load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       clr_last;
    logic       need_mark;
    logic       scan_empty;
    logic       scan_hit;
    logic       scan_last;
    logic       report_clear;
  } dp_sts_t;

endpackage

/* hdl/sbdt_ctrl.sv */
// ----------------------------------------------------------------------------
// sbdt_ctrl
// Sequencer for the dirty tracker: clearing pass, request decode, dirty bit
// read-modify-write, row-by-row flush scan and result strobe.
// ----------------------------------------------------------------------------
module sbdt_ctrl
  import sbdt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    out_valid
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RMW,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (sts.kind)
          KIND_READ, KIND_WRITE: begin
            if (sts.need_mark) begin
              cmd.rd_sel = RD_ACCESS;
              state_nxt  = S_RMW;
            end else begin
              state_nxt = S_FINISH;
            end
          end
          KIND_FLUSH: begin
            if (sts.scan_empty) begin
              state_nxt = S_FINISH;
            end else begin
              cmd.rd_sel = RD_CURSOR;
              state_nxt  = S_SCAN;
            end
          end
          default: begin
            if (sts.report_clear) begin
              cmd.rd_sel = RD_PENDING;
              state_nxt  = S_RMW;
            end else begin
              state_nxt = S_FINISH;
            end
          end
        endcase
      end
      S_RMW: begin
        if (sts.kind == KIND_REPORT) begin
          cmd.unmark = 1'b1;
        end else begin
          cmd.mark = 1'b1;
        end
        state_nxt = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan_eval = 1'b1;
        if (sts.scan_hit || sts.scan_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_FINISH: begin
        cmd.load      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/sbdt_datapath.sv */
// ----------------------------------------------------------------------------
// sbdt_datapath
// Configuration registers, window check, dirty bit memory, dirty and error
// counters, flush cursor and the result registers.
// ----------------------------------------------------------------------------
module sbdt_datapath
  import sbdt_pkg::*;
#(
  parameter int TRACKED_SECTORS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_lba,
  input  logic        in_write_ok,
  output logic [1:0]  out_status,
  output logic [1:0]  out_route,
  output logic [15:0] out_buffer_index,
  output logic [31:0] out_writeback_lba,
  output logic        out_writeback_valid,
  output logic [7:0]  out_drive,
  output logic        out_flush_done,
  output logic [9:0]  out_error_count,
  output logic [9:0]  out_dirty_count
);

  localparam int IDX_W  = ($clog2(TRACKED_SECTORS) > ROW_BW) ?
                          $clog2(TRACKED_SECTORS) : ROW_BW + 1;
  localparam int ROWS   = (TRACKED_SECTORS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = IDX_W - ROW_BW;
  localparam int TOT_W  = $clog2(TRACKED_SECTORS + 1);
  localparam int LW     = TOT_W + 1;

  // Configuration.
  logic [15:0] bs_r;
  logic [31:0] ps_r;
  logic        hw_r;
  logic [7:0]  drv_r;

  // Latched request.
  logic [1:0]  kind_r;
  logic [31:0] lba_r;
  logic        ok_r;

  // Tracking state.
  logic [TOT_W-1:0]  cursor_r;
  logic [CNT_W-1:0]  errors_r;
  logic [TOT_W-1:0]  total_r;
  logic [IDX_W-1:0]  pend_idx_r;
  logic              pend_v_r;
  logic [ROW_AW-1:0] clr_row_r;
  logic [ROW_AW-1:0] scan_row_r;

  // Dirty store.
  logic [ROW_W-1:0]  dirty_mem [ROWS];
  logic [ROW_W-1:0]  rd_data_r;
  logic [ROW_AW-1:0] rd_addr_r;
  logic [ROW_BW-1:0] rd_bit_r;
  logic [ROW_AW-1:0] rd_addr;
  logic [ROW_BW-1:0] rd_bit;
  logic              rd_en;
  logic              mem_we;
  logic [ROW_AW-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic [ROW_W-1:0]  bit_mask;
  logic              cur_dirty;

  // Working result.
  logic [1:0]  w_status_r;
  logic [1:0]  w_route_r;
  logic [15:0] w_bidx_r;
  logic [31:0] w_wlba_r;
  logic        w_wvalid_r;
  logic [7:0]  w_drive_r;
  logic        w_done_r;
  logic [9:0]  w_ecount_r;

  // Output registers.
  logic [1:0]  o_status_r;
  logic [1:0]  o_route_r;
  logic [15:0] o_bidx_r;
  logic [31:0] o_wlba_r;
  logic        o_wvalid_r;
  logic [7:0]  o_drive_r;
  logic        o_done_r;
  logic [9:0]  o_ecount_r;
  logic [9:0]  o_dirty_r;

  // Decode and scan terms.
  logic [31:0]       idx_full;
  logic              in_win;
  logic              need_mark;
  logic [TOT_W-1:0]  limit;
  logic [ROW_W-1:0]  cand;
  logic              scan_hit;
  logic [ROW_BW-1:0] hit_bit;
  logic [IDX_W-1:0]  found_idx;
  logic [LW-1:0]     next_base;
  logic              scan_last;
  logic              scan_empty;
  logic [31:0]       tot_ext;
  logic [CNT_W-1:0]  dirty_sat;

  assign idx_full  = lba_r - ps_r;
  assign in_win    = (bs_r != 16'd0) && (lba_r >= ps_r) && (idx_full < {16'd0, bs_r});
  assign need_mark = (kind_r == KIND_WRITE) && in_win &&
                     (idx_full < 32'(TRACKED_SECTORS));

  // The flush covers indices below the smaller of the window and the store.
  assign limit = ({16'd0, bs_r} < 32'(TRACKED_SECTORS)) ? bs_r[TOT_W-1:0] :
                 TOT_W'(TRACKED_SECTORS);
  assign scan_empty = (cursor_r >= limit);

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      cand[b] = rd_data_r[b] &&
                (LW'({scan_row_r, ROW_BW'(b)}) >= LW'(cursor_r)) &&
                (LW'({scan_row_r, ROW_BW'(b)}) < LW'(limit));
    end
  end

  // Lowest candidate wins.
  always_comb begin
    hit_bit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_bit = ROW_BW'(b);
      end
    end
  end

  assign scan_hit  = |cand;
  assign found_idx = {scan_row_r, hit_bit};
  assign next_base = LW'({scan_row_r, ROW_BW'(0)}) + LW'(ROW_W);
  assign scan_last = (next_base >= LW'(limit));

  assign tot_ext   = 32'(total_r);
  assign dirty_sat = (tot_ext > 32'(CNT_MAX)) ? CNT_MAX : tot_ext[CNT_W-1:0];

  assign sts.kind         = kind_r;
  assign sts.clr_last     = (clr_row_r == ROW_AW'(ROWS - 1));
  assign sts.need_mark    = need_mark;
  assign sts.scan_empty   = scan_empty;
  assign sts.scan_hit     = scan_hit;
  assign sts.scan_last    = scan_last;
  assign sts.report_clear = pend_v_r && ok_r;

  // Read address selection.
  always_comb begin
    rd_addr = '0;
    rd_bit  = '0;
    case (cmd.rd_sel)
      RD_ACCESS: begin
        rd_addr = idx_full[IDX_W-1:ROW_BW];
        rd_bit  = idx_full[ROW_BW-1:0];
      end
      RD_PENDING: begin
        rd_addr = pend_idx_r[IDX_W-1:ROW_BW];
        rd_bit  = pend_idx_r[ROW_BW-1:0];
      end
      RD_CURSOR: begin
        rd_addr = cursor_r[IDX_W-1:ROW_BW];
      end
      RD_NEXT: begin
        rd_addr = scan_row_r + 1'b1;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  assign rd_en     = (cmd.rd_sel != RD_NONE);
  assign bit_mask  = ROW_W'(1) << rd_bit_r;
  assign cur_dirty = rd_data_r[rd_bit_r];
  assign mem_we    = cmd.clr || cmd.mark || cmd.unmark;
  assign mem_waddr = cmd.clr ? clr_row_r : rd_addr_r;
  assign mem_wdata = cmd.clr  ? '0 :
                     cmd.mark ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dirty_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= dirty_mem[rd_addr];
      rd_addr_r <= rd_addr;
      rd_bit_r  <= rd_bit;
    end
    if (cmd.rd_sel == RD_CURSOR || cmd.rd_sel == RD_NEXT) begin
      scan_row_r <= rd_addr;
    end
  end

  // Configuration and tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r       <= 16'd0;
      ps_r       <= 32'd2048;
      hw_r       <= 1'b0;
      drv_r      <= 8'd128;
      cursor_r   <= '0;
      errors_r   <= '0;
      total_r    <= '0;
      pend_idx_r <= '0;
      pend_v_r   <= 1'b0;
      clr_row_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUFFERED:  bs_r  <= cfg_wdata[15:0];
          CFG_PARTITION: ps_r  <= cfg_wdata;
          CFG_HW:        hw_r  <= cfg_wdata[0];
          CFG_DRIVE:     drv_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
      if (cmd.clr) begin
        clr_row_r <= clr_row_r + 1'b1;
      end
      if (cmd.decode && kind_r == KIND_FLUSH) begin
        // A flush step drops any write-back still outstanding.
        pend_v_r <= 1'b0;
        if (scan_empty) begin
          cursor_r <= '0;
          errors_r <= '0;
        end
      end
      if (cmd.decode && kind_r == KIND_REPORT && pend_v_r) begin
        pend_v_r <= 1'b0;
        if (!ok_r && errors_r != CNT_MAX) begin
          errors_r <= errors_r + 1'b1;
        end
      end
      if (cmd.mark && !cur_dirty) begin
        total_r <= total_r + 1'b1;
      end
      if (cmd.unmark && cur_dirty) begin
        total_r <= total_r - 1'b1;
      end
      if (cmd.scan_eval) begin
        if (scan_hit) begin
          pend_idx_r <= found_idx;
          pend_v_r   <= 1'b1;
          cursor_r   <= TOT_W'(found_idx) + 1'b1;
        end else if (scan_last) begin
          cursor_r <= '0;
          errors_r <= '0;
        end
      end
    end
  end

  // Request capture, working result and output registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      lba_r  <= in_lba;
      ok_r   <= in_write_ok;
    end
    if (cmd.decode) begin
      w_status_r <= STATUS_OK;
      w_route_r  <= ROUTE_NONE;
      w_bidx_r   <= 16'd0;
      w_wlba_r   <= 32'd0;
      w_wvalid_r <= 1'b0;
      w_drive_r  <= 8'd0;
      w_done_r   <= 1'b0;
      w_ecount_r <= 10'd0;
      if (kind_r == KIND_READ || kind_r == KIND_WRITE) begin
        if (bs_r != 16'd0) begin
          if (in_win) begin
            w_route_r <= ROUTE_RAM;
            w_bidx_r  <= idx_full[15:0];
          end else begin
            w_status_r <= STATUS_RANGE;
          end
        end else if (hw_r) begin
          w_route_r <= ROUTE_PIO;
        end else begin
          w_status_r <= STATUS_NODEV;
        end
      end else if (kind_r == KIND_FLUSH && scan_empty) begin
        w_done_r   <= 1'b1;
        w_ecount_r <= errors_r;
      end
    end
    if (cmd.scan_eval) begin
      if (scan_hit) begin
        w_wvalid_r <= 1'b1;
        w_wlba_r   <= ps_r + 32'(found_idx);
        w_route_r  <= hw_r ? ROUTE_PIO : ROUTE_BIOS;
        w_drive_r  <= hw_r ? 8'd0 : drv_r;
      end else if (scan_last) begin
        w_done_r   <= 1'b1;
        w_ecount_r <= errors_r;
      end
    end
    if (cmd.load) begin
      o_status_r <= w_status_r;
      o_route_r  <= w_route_r;
      o_bidx_r   <= w_bidx_r;
      o_wlba_r   <= w_wlba_r;
      o_wvalid_r <= w_wvalid_r;
      o_drive_r  <= w_drive_r;
      o_done_r   <= w_done_r;
      o_ecount_r <= w_ecount_r;
      o_dirty_r  <= dirty_sat;
    end
  end

  assign out_status          = o_status_r;
  assign out_route           = o_route_r;
  assign out_buffer_index    = o_bidx_r;
  assign out_writeback_lba   = o_wlba_r;
  assign out_writeback_valid = o_wvalid_r;
  assign out_drive           = o_drive_r;
  assign out_flush_done      = o_done_r;
  assign out_error_count     = o_ecount_r;
  assign out_dirty_count     = o_dirty_r;

endmodule

/* hdl/sector_buffer_dirty_tracker.sv */
// ----------------------------------------------------------------------------
// sector_buffer_dirty_tracker
// Routes sector requests to the RAM buffer or the disk and tracks dirty
// buffered sectors for a stepwise write-back flush.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with out_valid, and the receiver must take
// it then. A write that marks a sector and a report that clears a pending
// write-back also pass through a read-modify-write state, as the dirty row
// is read and then written back. A flush step scans the dirty store row by
// row, 8 sectors per row, until it finds a dirty sector or reaches the end
// of the scan range. After reset, busy stays high while the dirty store is
// cleared; configuration writes are taken during that pass.
module sector_buffer_dirty_tracker
  import sbdt_pkg::*;
#(
  parameter int TRACKED_SECTORS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_lba,
  input  logic        in_write_ok,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [1:0]  out_route,
  output logic [15:0] out_buffer_index,
  output logic [31:0] out_writeback_lba,
  output logic        out_writeback_valid,
  output logic [7:0]  out_drive,
  output logic        out_flush_done,
  output logic [9:0]  out_error_count,
  output logic [9:0]  out_dirty_count
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sbdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sbdt_datapath #(
    .TRACKED_SECTORS (TRACKED_SECTORS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_kind             (in_kind),
    .in_lba              (in_lba),
    .in_write_ok         (in_write_ok),
    .out_status          (out_status),
    .out_route           (out_route),
    .out_buffer_index    (out_buffer_index),
    .out_writeback_lba   (out_writeback_lba),
    .out_writeback_valid (out_writeback_valid),
    .out_drive           (out_drive),
    .out_flush_done      (out_flush_done),
    .out_error_count     (out_error_count),
    .out_dirty_count     (out_dirty_count)
  );

endmodule

/* hdl/sbdt_checker.sv */
// ----------------------------------------------------------------------------
// sbdt_checker
// Port-level checks on the dirty tracker's request and result behavior.
// ----------------------------------------------------------------------------
module sbdt_checker
  import sbdt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [1:0] out_route,
  input logic       out_writeback_valid,
  input logic       out_flush_done,
  input logic [9:0] out_error_count
);

  // An accepted transaction must raise busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flush_done |->
      !out_writeback_valid && out_route == ROUTE_NONE && out_status == STATUS_OK)
    else $error("finished flush carries a write-back request");

  a_errcount_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flush_done |-> out_error_count == 10'd0)
    else $error("error count outside a finished flush");

endmodule

bind sector_buffer_dirty_tracker sbdt_checker u_sbdt_checker (.*);

/* tb/tb_sector_buffer_dirty_tracker.sv */
// ----------------------------------------------------------------------------
// tb_sector_buffer_dirty_tracker
// Self-checking bench for the sector buffer dirty tracker. A driver feeds
// requests from a queue with random gaps, a local model of the router and
// dirty bitmap predicts every result, and a monitor compares each strobed
// result field by field. Configuration changes happen between traffic
// phases, once the block has gone idle.
// ----------------------------------------------------------------------------
module tb_sector_buffer_dirty_tracker;
  import sbdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRACKED = 512;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] lba;
    logic        write_ok;
  } sector_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [1:0]  route;
    logic [15:0] buffer_index;
    logic [31:0] writeback_lba;
    logic        writeback_valid;
    logic [7:0]  drive;
    logic        flush_done;
    logic [9:0]  error_count;
    logic [9:0]  dirty_count;
  } sector_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = KIND_READ;
  logic [31:0] in_lba = '0;
  logic        in_write_ok = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_BUFFERED;
  logic [31:0] cfg_wdata = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [1:0]  out_route;
  logic [15:0] out_buffer_index;
  logic [31:0] out_writeback_lba;
  logic        out_writeback_valid;
  logic [7:0]  out_drive;
  logic        out_flush_done;
  logic [9:0]  out_error_count;
  logic [9:0]  out_dirty_count;

  sector_buffer_dirty_tracker #(
    .TRACKED_SECTORS(TRACKED)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_lba              (in_lba),
    .in_write_ok         (in_write_ok),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_route           (out_route),
    .out_buffer_index    (out_buffer_index),
    .out_writeback_lba   (out_writeback_lba),
    .out_writeback_valid (out_writeback_valid),
    .out_drive           (out_drive),
    .out_flush_done      (out_flush_done),
    .out_error_count     (out_error_count),
    .out_dirty_count     (out_dirty_count)
  );

  always #4 clk = ~clk;

  sector_req_t queued_requests[$];
  sector_res_t due_results[$];
  int          issued = 0;
  int          mismatches = 0;
  bit          no_gaps = 1'b0;

  // Local copy of the configuration and the tracking state.
  logic [15:0] m_buffered;
  logic [31:0] m_partition;
  logic        m_hw;
  logic [7:0]  m_drive;
  bit          dirty_map[TRACKED];
  logic [9:0]  m_cursor;
  logic [9:0]  m_errors;
  logic [9:0]  m_total;
  logic [9:0]  m_pend_idx;
  bit          m_pend_valid;

  function automatic void reset_tracker();
    m_buffered   = 16'd0;
    m_partition  = 32'd2048;
    m_hw         = 1'b0;
    m_drive      = 8'd128;
    foreach (dirty_map[i]) dirty_map[i] = 1'b0;
    m_cursor     = '0;
    m_errors     = '0;
    m_total      = '0;
    m_pend_idx   = '0;
    m_pend_valid = 1'b0;
  endfunction

  function automatic sector_res_t track_request(sector_req_t r);
    sector_res_t res;
    logic [31:0] idx;
    int unsigned lim;
    int unsigned i;
    res = '{default: '0};
    res.status = STATUS_OK;
    res.route  = ROUTE_NONE;
    case (r.kind)
      KIND_READ, KIND_WRITE: begin
        if (m_buffered != 16'd0) begin
          idx = r.lba - m_partition;
          if (r.lba < m_partition || idx >= {16'd0, m_buffered}) begin
            res.status = STATUS_RANGE;
          end else begin
            res.route        = ROUTE_RAM;
            res.buffer_index = idx[15:0];
            // Sectors past the tracked range are buffered but never marked.
            if (r.kind == KIND_WRITE && idx < TRACKED && !dirty_map[idx]) begin
              dirty_map[idx] = 1'b1;
              m_total++;
            end
          end
        end else if (m_hw) begin
          res.route = ROUTE_PIO;
        end else begin
          res.status = STATUS_NODEV;
        end
      end
      KIND_FLUSH: begin
        lim = (m_buffered < TRACKED) ? m_buffered : TRACKED;
        i = 32'(m_cursor);
        // A write-back still outstanding is simply dropped.
        m_pend_valid = 1'b0;
        while (i < lim && !dirty_map[i]) i++;
        if (i < lim) begin
          res.writeback_valid = 1'b1;
          res.writeback_lba   = m_partition + i;
          res.route           = m_hw ? ROUTE_PIO : ROUTE_BIOS;
          res.drive           = m_hw ? 8'd0 : m_drive;
          m_pend_idx          = 10'(i);
          m_pend_valid        = 1'b1;
          m_cursor            = 10'(i + 1);
        end else begin
          res.flush_done  = 1'b1;
          res.error_count = m_errors;
          m_cursor        = '0;
          m_errors        = '0;
        end
      end
      default: begin
        if (m_pend_valid) begin
          m_pend_valid = 1'b0;
          if (r.write_ok) begin
            if (dirty_map[m_pend_idx]) begin
              dirty_map[m_pend_idx] = 1'b0;
              m_total--;
            end
          end else if (m_errors < CNT_MAX) begin
            m_errors++;
          end
        end
      end
    endcase
    res.dirty_count = m_total;
    return res;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // Driver: a transaction is taken on an edge with start high and busy low.
  always @(posedge clk) begin : request_driver
    sector_req_t req;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        req.kind     = in_kind;
        req.lba      = in_lba;
        req.write_ok = in_write_ok;
        due_results.push_back(track_request(req));
      end
      if (!start || !busy) begin
        if (queued_requests.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 36)) begin
          req = queued_requests.pop_front();
          start       <= 1'b1;
          in_kind     <= req.kind;
          in_lba      <= req.lba;
          in_write_ok <= req.write_ok;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    sector_res_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (due_results.size() == 0) begin
        note_mismatch("result strobe with no transaction outstanding");
      end else begin
        want = due_results.pop_front();
        check_field("status", 32'(out_status), 32'(want.status));
        check_field("route", 32'(out_route), 32'(want.route));
        check_field("buffer_index", 32'(out_buffer_index), 32'(want.buffer_index));
        check_field("writeback_lba", out_writeback_lba, want.writeback_lba);
        check_field("writeback_valid", 32'(out_writeback_valid),
                    32'(want.writeback_valid));
        check_field("drive", 32'(out_drive), 32'(want.drive));
        check_field("flush_done", 32'(out_flush_done), 32'(want.flush_done));
        check_field("error_count", 32'(out_error_count), 32'(want.error_count));
        check_field("dirty_count", 32'(out_dirty_count), 32'(want.dirty_count));
      end
    end
  end

  task automatic push_req(input logic [1:0] k, input logic [31:0] a, input logic ok);
    sector_req_t req;
    req.kind     = k;
    req.lba      = a;
    req.write_ok = ok;
    queued_requests.push_back(req);
    issued++;
  endtask

  task automatic wait_idle();
    while (queued_requests.size() != 0 || start || due_results.size() != 0 || busy)
      @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_BUFFERED:  m_buffered  = data[15:0];
      CFG_PARTITION: m_partition = data;
      CFG_HW:        m_hw        = data[0];
      default:       m_drive     = data[7:0];
    endcase
  endtask

  task automatic configure(input logic [31:0] bufs, input logic [31:0] part,
                           input logic [31:0] hw, input logic [31:0] drv);
    wait_idle();
    cfg_write(CFG_BUFFERED, bufs);
    cfg_write(CFG_PARTITION, part);
    cfg_write(CFG_HW, hw);
    cfg_write(CFG_DRIVE, drv);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly addresses inside the buffered window, with its edges and strays.
  function automatic logic [31:0] window_lba();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (m_buffered == 16'd0 || pick == 3) return $urandom;
    case (pick)
      0:       return m_partition - 1;
      1:       return m_partition + m_buffered;
      2:       return m_partition + m_buffered - 1;
      default: return m_partition + $urandom_range(0, m_buffered - 1);
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] bufs;
    logic [31:0] part;
    case ($urandom_range(0, 9))
      0:       bufs = 0;
      1:       bufs = 65535;
      2:       bufs = $urandom_range(513, 1000);
      3, 4:    bufs = $urandom_range(100, 512);
      default: bufs = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 5))
      0:       part = 0;
      1:       part = 32'hFFFF_FFFF - $urandom_range(0, 100);
      2:       part = $urandom;
      default: part = 2048 + $urandom_range(0, 5000);
    endcase
    // Bits above each register's width are junk and must be ignored.
    configure({16'($urandom_range(0, 65535)), bufs[15:0]}, part,
              {16'($urandom_range(0, 65535)), 15'($urandom), 1'($urandom)},
              {24'($urandom), 8'($urandom)});
  endtask

  task automatic traffic_burst();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      n = $urandom_range(1, 6);
      repeat (n) push_req(KIND_WRITE, window_lba(), 1'($urandom));
    end else if (sel < 55) begin
      n = $urandom_range(1, 4);
      repeat (n) push_req(KIND_READ, window_lba(), 1'($urandom));
    end else if (sel < 85) begin
      // Flush steps, most of them answered by a write-back report.
      n = $urandom_range(1, 10);
      repeat (n) begin
        push_req(KIND_FLUSH, $urandom, 1'($urandom));
        if ($urandom_range(0, 9) < 8)
          push_req(KIND_REPORT, $urandom, $urandom_range(0, 3) != 0);
      end
    end else begin
      push_req(2'($urandom), $urandom, 1'($urandom));
    end
  endtask

  initial begin : stimulus
    int target;
    reset_tracker();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Buffer mode off, no disk: accesses fail and a flush ends at once.
    push_req(KIND_READ, 32'h0000_0000, 1'b0);
    push_req(KIND_WRITE, 32'hFFFF_FFFF, 1'b1);
    push_req(KIND_FLUSH, 32'h0000_0000, 1'b0);
    push_req(KIND_REPORT, 32'hFFFF_FFFF, 1'b1);

    configure(0, 2048, 1, 128);
    push_req(KIND_WRITE, 32'd123, 1'b0);

    configure(16, 2048, 0, 255);
    push_req(KIND_READ, 32'd2047, 1'b0);
    push_req(KIND_READ, 32'd2048, 1'b0);
    push_req(KIND_WRITE, 32'd2063, 1'b0);
    push_req(KIND_WRITE, 32'd2064, 1'b0);
    push_req(KIND_WRITE, 32'd2048, 1'b0);
    push_req(KIND_WRITE, 32'd2050, 1'b1);
    push_req(KIND_FLUSH, 32'd0, 1'b0);
    push_req(KIND_REPORT, 32'd0, 1'b1);
    push_req(KIND_FLUSH, 32'd0, 1'b0);
    // This step drops the write-back still outstanding.
    push_req(KIND_FLUSH, 32'd0, 1'b0);
    push_req(KIND_FLUSH, 32'd0, 1'b0);
    push_req(KIND_REPORT, 32'd0, 1'b0);
    push_req(KIND_FLUSH, 32'd0, 1'b0);

    // Past the tracked range a write is buffered but not marked.
    configure(600, 0, 1, 0);
    push_req(KIND_WRITE, 32'd520, 1'b1);
    push_req(KIND_WRITE, 32'd511, 1'b1);
    push_req(KIND_READ, 32'd65535, 1'b0);

    // Dirty sectors above the scan limit are left alone.
    configure(16, 32'hFFFF_FF00, 0, 128);
    push_req(KIND_FLUSH, 32'd0, 1'b0);

    // The write-back address wraps past the top of the LBA space.
    configure(65535, 32'hFFFF_FF00, 0, 128);
    push_req(KIND_FLUSH, 32'd0, 1'b0);
    push_req(KIND_REPORT, 32'd0, 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) configure(65535, 32'hFFFF_FFFF, 1, 255);
      else random_config();
      no_gaps = (ph == 4);
      target = issued + 125;
      while (issued < target) traffic_burst();
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_sector_buffer_dirty_tracker: PASS");
    end else begin
      $display("tb_sector_buffer_dirty_tracker: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb_sector_buffer_dirty_tracker: FAIL");
    $finish;
  end

endmodule
